// ----- hw/rtl/lzwc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lzwc_pkg
// Shared types and constants of the 13-bit variable-width dictionary coder.
// ----------------------------------------------------------------------------
package lzwc_pkg;

    localparam int MAX_CODE_BITS = 13;
    localparam int MIN_CODE_BITS = 9;
    localparam int HASH_DEPTH    = 16384;
    localparam int HASH_BITS     = $clog2(HASH_DEPTH);

    localparam int CODE_W  = MAX_CODE_BITS;
    localparam int KEY_W   = CODE_W + 8;
    localparam int BUF_W   = CODE_W + 8;
    localparam int CNT_W   = $clog2(BUF_W);
    localparam int WID_W   = $clog2(MAX_CODE_BITS + 1);
    localparam int EPOCH_W = 8;

    localparam logic [CODE_W-1:0]    CLEAR_CODE = CODE_W'(256);
    localparam logic [CODE_W-1:0]    FIRST_FREE = CODE_W'(257);
    localparam logic [CODE_W-1:0]    CODE_LIMIT = CODE_W'((1 << MAX_CODE_BITS) - 2);
    localparam logic [HASH_BITS-1:0] HASH_MULT  = HASH_BITS'(32'h9E3779B1);
    localparam logic [HASH_BITS-1:0] HASH_LAST  = HASH_BITS'(HASH_DEPTH - 1);
    localparam logic [EPOCH_W-1:0]   EPOCH_MAX  = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0]   EPOCH_ONE  = EPOCH_W'(1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [KEY_W-1:0]   key;
        logic [CODE_W-1:0]  code;
    } entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lzw_compressor_13bit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lzw_compressor_13bit
// Dictionary coder: hashed dictionary in one synchronous RAM, codes of
// 9 to 13 bits packed most significant bit first into output bytes.
// ----------------------------------------------------------------------------
// Sequence: a byte that hits on the first probe passes through start, hash,
//   probe, check and finish back to idle; each extra probe repeats probe and check.
// A miss also drains its packed bytes; a clear code and a stream end add their
//   own states and bytes. The first byte of a stream only sets the prefix. A
//   new byte is taken only in idle; output stalls hold the drain.
// Reset: control clears at once; then a clearing pass writes all 16384 RAM
//   entries before the first transfer. The pass repeats once every 255
//   dictionary clears or stream ends, when the epoch mark wraps.
// ----------------------------------------------------------------------------
module lzw_compressor_13bit
    import lzwc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      src_valid,
    output logic           src_stall,
    input  wire in_item_t  src_item,
    output logic           snk_valid,
    input  wire logic      snk_stall,
    output out_item_t      snk_item
);

    localparam logic [3:0] S_SWEEP   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_START   = 4'd2;
    localparam logic [3:0] S_POSTCLR = 4'd3;
    localparam logic [3:0] S_HASH    = 4'd4;
    localparam logic [3:0] S_PROBE   = 4'd5;
    localparam logic [3:0] S_CHECK   = 4'd6;
    localparam logic [3:0] S_FIN     = 4'd7;
    localparam logic [3:0] S_FIN2    = 4'd8;
    localparam logic [3:0] S_PAD     = 4'd9;
    localparam logic [3:0] S_DRAIN   = 4'd10;

    entry_t mem [HASH_DEPTH];
    entry_t rd_reg;

    logic [3:0]           state_reg, state_next;
    logic [3:0]           ret_reg, ret_next;
    logic [3:0]           sweep_ret_reg, sweep_ret_next;
    logic [HASH_BITS-1:0] sweep_addr_reg, sweep_addr_next;
    logic [EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic                 wrap_reg, wrap_next;
    logic [CODE_W-1:0]    prefix_reg, prefix_next;
    logic                 have_reg, have_next;
    logic [CODE_W-1:0]    next_code_reg, next_code_next;
    logic [BUF_W-1:0]     buf_reg, buf_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 final_reg, final_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 last_reg, last_next;
    logic [HASH_BITS-1:0] slot_reg, slot_next;
    logic [HASH_BITS-1:0] probe_reg, probe_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_reg, out_next;

    logic                 mem_we;
    logic [HASH_BITS-1:0] mem_waddr;
    entry_t               mem_wdata;
    logic                 mem_re;

    logic                 do_put;
    logic [CODE_W-1:0]    put_val;
    logic [WID_W-1:0]     put_w;
    logic [BUF_W-1:0]     put_mask;
    logic [KEY_W-1:0]     key;
    logic [2*HASH_BITS-1:0] hash_prod;
    logic                 out_free;
    logic                 over_limit;

    // Width of the next code from the dictionary fill
    function automatic logic [WID_W-1:0] code_width_of(input logic [CODE_W-1:0] nc);
        logic [WID_W-1:0] w;
        w = WID_W'(MIN_CODE_BITS);
        for (int i = MIN_CODE_BITS; i < MAX_CODE_BITS; i++) begin
            if ((32'd1 << i) < 32'(nc)) begin
                w = WID_W'(i + 1);
            end
        end
        return w;
    endfunction

    assign key        = {prefix_reg, byte_reg};
    assign hash_prod  = key[HASH_BITS-1:0] * HASH_MULT;
    assign out_free   = !out_valid_reg || !snk_stall;
    assign over_limit = next_code_reg > CODE_LIMIT;
    assign put_w      = code_width_of(next_code_reg);
    assign put_mask   = (BUF_W'(1) << put_w) - BUF_W'(1);
    assign mem_re     = (state_reg == S_PROBE);

    assign src_stall  = (state_reg != S_IDLE);
    assign snk_valid  = out_valid_reg;
    assign snk_item   = out_reg;

    // Sequence one byte through probe, insert, emission and flush
    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        sweep_ret_next  = sweep_ret_reg;
        sweep_addr_next = sweep_addr_reg;
        epoch_next      = epoch_reg;
        wrap_next       = wrap_reg;
        prefix_next     = prefix_reg;
        have_next       = have_reg;
        next_code_next  = next_code_reg;
        buf_next        = buf_reg;
        cnt_next        = cnt_reg;
        final_next      = final_reg;
        byte_next       = byte_reg;
        last_next       = last_reg;
        slot_next       = slot_reg;
        probe_next      = probe_reg;
        out_valid_next  = out_valid_reg && snk_stall;
        out_next        = out_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = '{epoch: epoch_reg, key: key, code: next_code_reg};
        do_put          = 1'b0;
        put_val         = prefix_reg;

        unique case (state_reg)
            S_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = '0;
                sweep_addr_next = sweep_addr_reg + HASH_BITS'(1);
                if (sweep_addr_reg == HASH_LAST) begin
                    state_next = sweep_ret_reg;
                end
            end
            S_IDLE:
            begin
                if (src_valid) begin
                    byte_next = src_item.data_byte;
                    last_next = src_item.is_last;
                    if (!have_reg) begin
                        prefix_next = CODE_W'(src_item.data_byte);
                        have_next   = 1'b1;
                        state_next  = src_item.is_last ? S_FIN : S_IDLE;
                    end else begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                if (over_limit) begin
                    // emit clear code, then empty the table by advancing the epoch
                    do_put         = 1'b1;
                    put_val        = CLEAR_CODE;
                    next_code_next = FIRST_FREE;
                    if (epoch_reg == EPOCH_MAX) begin
                        epoch_next = EPOCH_ONE;
                        wrap_next  = 1'b1;
                    end else begin
                        epoch_next = epoch_reg + EPOCH_ONE;
                        wrap_next  = 1'b0;
                    end
                    ret_next   = S_POSTCLR;
                    state_next = S_DRAIN;
                end else begin
                    state_next = S_HASH;
                end
            end
            S_POSTCLR:
            begin
                if (wrap_reg) begin
                    sweep_addr_next = '0;
                    sweep_ret_next  = S_HASH;
                    state_next      = S_SWEEP;
                end else begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                slot_next  = hash_prod[HASH_BITS-1:0];
                probe_next = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (rd_reg.epoch != epoch_reg) begin
                    // free slot: insert and emit the prefix
                    mem_we         = 1'b1;
                    do_put         = 1'b1;
                    next_code_next = next_code_reg + CODE_W'(1);
                    prefix_next    = CODE_W'(byte_reg);
                    ret_next       = S_FIN;
                    state_next     = S_DRAIN;
                end else if (rd_reg.key == key) begin
                    prefix_next = rd_reg.code;
                    state_next  = S_FIN;
                end else if (probe_reg == HASH_LAST) begin
                    // table full: drop the insert, still use up the code
                    do_put         = 1'b1;
                    next_code_next = next_code_reg + CODE_W'(1);
                    prefix_next    = CODE_W'(byte_reg);
                    ret_next       = S_FIN;
                    state_next     = S_DRAIN;
                end else begin
                    slot_next  = slot_reg + HASH_BITS'(1);
                    probe_next = probe_reg + HASH_BITS'(1);
                    state_next = S_PROBE;
                end
            end
            S_FIN:
            begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (over_limit) begin
                    do_put         = 1'b1;
                    put_val        = CLEAR_CODE;
                    next_code_next = FIRST_FREE;
                    ret_next       = S_FIN2;
                    state_next     = S_DRAIN;
                end else begin
                    state_next = S_FIN2;
                end
            end
            S_FIN2:
            begin
                do_put     = 1'b1;
                final_next = 1'b1;
                ret_next   = S_PAD;
                state_next = S_DRAIN;
            end
            S_PAD:
            begin
                if (cnt_reg == '0 || out_free) begin
                    if (cnt_reg != '0) begin
                        out_valid_next    = 1'b1;
                        out_next.out_byte = 8'(buf_reg << (CNT_W'(8) - cnt_reg));
                        out_next.out_last = 1'b1;
                    end
                    // return to the reset state for a new stream
                    prefix_next    = '0;
                    have_next      = 1'b0;
                    next_code_next = FIRST_FREE;
                    buf_next       = '0;
                    cnt_next       = '0;
                    final_next     = 1'b0;
                    if (epoch_reg == EPOCH_MAX) begin
                        epoch_next      = EPOCH_ONE;
                        sweep_addr_next = '0;
                        sweep_ret_next  = S_IDLE;
                        state_next      = S_SWEEP;
                    end else begin
                        epoch_next = epoch_reg + EPOCH_ONE;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DRAIN:
            begin
                if (cnt_reg >= CNT_W'(8)) begin
                    if (out_free) begin
                        out_valid_next    = 1'b1;
                        out_next.out_byte = 8'(buf_reg >> (cnt_reg - CNT_W'(8)));
                        out_next.out_last = final_reg && (cnt_reg == CNT_W'(8));
                        cnt_next          = cnt_reg - CNT_W'(8);
                    end
                end else begin
                    state_next = ret_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // append one code to the bit buffer
        if (do_put) begin
            buf_next = (buf_reg << put_w) | (BUF_W'(put_val) & put_mask);
            cnt_next = cnt_reg + CNT_W'(put_w);
        end
    end

    // Hold the dictionary RAM
    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_reg <= mem[slot_reg];
        end
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= S_SWEEP;
            ret_reg        <= S_IDLE;
            sweep_ret_reg  <= S_IDLE;
            sweep_addr_reg <= '0;
            epoch_reg      <= EPOCH_ONE;
            wrap_reg       <= 1'b0;
            prefix_reg     <= '0;
            have_reg       <= 1'b0;
            next_code_reg  <= FIRST_FREE;
            buf_reg        <= '0;
            cnt_reg        <= '0;
            final_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            sweep_ret_reg  <= sweep_ret_next;
            sweep_addr_reg <= sweep_addr_next;
            epoch_reg      <= epoch_next;
            wrap_reg       <= wrap_next;
            prefix_reg     <= prefix_next;
            have_reg       <= have_next;
            next_code_reg  <= next_code_next;
            buf_reg        <= buf_next;
            cnt_reg        <= cnt_next;
            final_reg      <= final_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        slot_reg  <= slot_next;
        probe_reg <= probe_next;
        out_reg   <= out_next;
    end

    // Checks
    a_idle_partial: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cnt_reg < CNT_W'(8)))
        else $error("partial byte holds eight or more bits while idle");

    a_code_floor: assert property (@(posedge clk) disable iff (!rst_n)
        next_code_reg >= FIRST_FREE)
        else $error("next code below first free code");

    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != '0)
        else $error("epoch mark equals the cleared mark");

    a_sweep_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> (src_stall && !mem_re))
        else $error("transfer or read during clearing pass");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into the dictionary coder and checks each packed output
// byte against an in-bench dictionary coder with the same hash and probing.
// ----------------------------------------------------------------------------
module testbench;
    import lzwc_pkg::*;

    localparam int N_DIRECTED  = 20;
    localparam int N_RANDOM    = 240;
    localparam int HOLD_CYCLES = 400;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    in_item_t  src_item;
    logic      snk_valid;
    logic      snk_stall;
    out_item_t snk_item;

    lzw_compressor_13bit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .snk_valid (snk_valid),
        .snk_stall (snk_stall),
        .snk_item  (snk_item)
    );

    // Predictor state
    bit          dict_used [HASH_DEPTH];
    logic [20:0] dict_key  [HASH_DEPTH];
    logic [12:0] dict_code [HASH_DEPTH];
    logic [12:0] cur_prefix;
    bit          prefix_held;
    int unsigned code_next;
    logic [31:0] pack_buf;
    int unsigned pack_cnt;

    out_item_t   expected_bytes[$];
    int          pending_n;
    bit          failed;
    bit          hold_off;

    typedef struct {
        logic [7:0] data_byte;
        bit         is_last;
        int         n_known;
        logic [7:0] known0;
        bit         known0_last;
    } row_t;

    row_t directed_rows[N_DIRECTED];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Return the predictor to its after-reset state
    function automatic void clear_coder(bit keep_dict);
        if (!keep_dict)
            foreach (dict_used[i]) dict_used[i] = 1'b0;
        cur_prefix  = '0;
        prefix_held = 1'b0;
        code_next   = 32'(FIRST_FREE);
        pack_buf    = '0;
        pack_cnt    = 0;
    endfunction

    function automatic void emit_packed(logic [7:0] b, bit last);
        out_item_t r;
        r.out_byte = b;
        r.out_last = last;
        expected_bytes = {expected_bytes, r};
        pending_n++;
    endfunction

    // Pack one code at the width set by the current code count
    function automatic void pack_code(int unsigned code);
        int unsigned w;
        w = MIN_CODE_BITS;
        while (w < MAX_CODE_BITS && (1 << w) < code_next)
            w++;
        pack_buf = (pack_buf << w) | (code & ((1 << w) - 1));
        pack_cnt += w;
        while (pack_cnt >= 8)
        begin
            emit_packed(8'(pack_buf >> (pack_cnt - 8)), 1'b0);
            pack_cnt -= 8;
            pack_buf &= (32'd1 << pack_cnt) - 1;
        end
    endfunction

    // Work out the packed bytes caused by one input byte
    function automatic void code_byte(logic [7:0] b, bit last);
        logic [20:0] k;
        int unsigned s;
        int unsigned n;
        int          hit_code;
        int          free_slot;
        int          before_n;
        before_n = expected_bytes.size();
        if (!prefix_held)
        begin
            cur_prefix  = 13'(b);
            prefix_held = 1'b1;
        end
        else
        begin
            if (code_next > 32'(CODE_LIMIT))
            begin
                pack_code(32'(CLEAR_CODE));
                foreach (dict_used[i]) dict_used[i] = 1'b0;
                code_next = 32'(FIRST_FREE);
            end
            k = {cur_prefix, b};
            s = (32'(k) * 32'h9E3779B1) % HASH_DEPTH;
            hit_code  = -1;
            free_slot = -1;
            for (n = 0; n < HASH_DEPTH; n++)
            begin
                if (!dict_used[s])
                begin
                    free_slot = s;
                    break;
                end
                if (dict_key[s] == k)
                begin
                    hit_code = dict_code[s];
                    break;
                end
                s = (s + 1) % HASH_DEPTH;
            end
            if (hit_code >= 0)
                cur_prefix = 13'(hit_code);
            else
            begin
                pack_code(32'(cur_prefix));
                if (free_slot >= 0)
                begin
                    dict_used[free_slot] = 1'b1;
                    dict_key[free_slot]  = k;
                    dict_code[free_slot] = 13'(code_next);
                end
                code_next++;
                cur_prefix = 13'(b);
            end
        end
        if (last)
        begin
            if (code_next > 32'(CODE_LIMIT))
            begin
                pack_code(32'(CLEAR_CODE));
                code_next = 32'(FIRST_FREE);
            end
            pack_code(32'(cur_prefix));
            if (pack_cnt > 0)
                emit_packed(8'(pack_buf << (8 - pack_cnt)), 1'b1);
            else if (expected_bytes.size() > before_n)
                expected_bytes[expected_bytes.size() - 1].out_last = 1'b1;
            clear_coder(1'b0);
        end
    endfunction

    // Offer one byte and hold it until the transfer
    task automatic send_byte(logic [7:0] b, bit last);
        src_valid          <= 1'b1;
        src_item.data_byte <= b;
        src_item.is_last   <= last;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        code_byte(b, last);
    endtask

    task automatic sender_gap();
        int g;
        g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
        if (g > 0)
        begin
            src_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Compare each transfer on the output with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && snk_valid && !snk_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected output byte %0h", snk_item.out_byte);
                failed = 1'b1;
            end
            else
            begin
                out_item_t e;
                e = expected_bytes.pop_front();
                if (snk_item.out_byte !== e.out_byte)
                begin
                    $error("out_byte expected %0h actual %0h", e.out_byte,
                        snk_item.out_byte);
                    failed = 1'b1;
                end
                if (snk_item.out_last !== e.out_last)
                begin
                    $error("out_last expected %0b actual %0b", e.out_last,
                        snk_item.out_last);
                    failed = 1'b1;
                end
            end
        end
    end

    // Stall the output on a pattern of its own, with one long hold-off
    initial
    begin
        int phase;
        snk_stall = 1'b1;
        phase     = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase++;
            if (hold_off)
                snk_stall <= 1'b1;
            else if ((phase / 64) % 3 == 0)
                snk_stall <= 1'b0;
            else
                snk_stall <= ($urandom_range(0, 2) == 0);
        end
    end

    // Long hold-off while the sender keeps offering bytes
    initial
    begin
        hold_off = 1'b0;
        wait (rst_n);
        repeat (17000 + 300) @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        int i;
        int left;
        int run_len;
        logic [7:0] b;
        logic [7:0] alpha;
        failed      = 1'b0;
        pending_n   = 0;
        rst_n       = 1'b0;
        src_valid   = 1'b0;
        src_item    = '0;
        clear_coder(1'b0);

        // Directed rows: lone bytes give fixed codes, extremes of the byte
        directed_rows[0]  = '{8'h00, 1'b1, 2, 8'h00, 1'b0};
        directed_rows[1]  = '{8'hFF, 1'b1, 2, 8'h7F, 1'b0};
        directed_rows[2]  = '{8'hAA, 1'b1, 2, 8'h55, 1'b0};
        directed_rows[3]  = '{8'h55, 1'b0, 0, 8'h00, 1'b0};
        directed_rows[4]  = '{8'h55, 1'b0, 0, 8'h00, 1'b0};
        directed_rows[5]  = '{8'h55, 1'b0, 0, 8'h00, 1'b0};
        directed_rows[6]  = '{8'h55, 1'b1, 0, 8'h00, 1'b0};
        for (i = 7; i < N_DIRECTED; i++)
            directed_rows[i] = '{8'((i % 3) * 8'h81), (i == N_DIRECTED - 1), 0,
                8'h00, 1'b0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            int before_n;
            int new_n;
            int first_idx;
            before_n = pending_n;
            send_byte(directed_rows[r].data_byte, directed_rows[r].is_last);
            // the new bytes sit at the tail; older ones may already be gone
            new_n     = pending_n - before_n;
            first_idx = expected_bytes.size() - new_n;
            if (directed_rows[r].n_known > 0)
            begin
                if (new_n != directed_rows[r].n_known)
                begin
                    $error("table row %0d: byte count expected %0d predicted %0d", r,
                        directed_rows[r].n_known, new_n);
                    failed = 1'b1;
                end
                else if (expected_bytes[first_idx].out_byte != directed_rows[r].known0)
                begin
                    $error("table row %0d: out_byte expected %0h predicted %0h", r,
                        directed_rows[r].known0, expected_bytes[first_idx].out_byte);
                    failed = 1'b1;
                end
                else if (expected_bytes[first_idx].out_last !=
                         directed_rows[r].known0_last)
                begin
                    $error("table row %0d: out_last expected %0b predicted %0b", r,
                        directed_rows[r].known0_last,
                        expected_bytes[first_idx].out_last);
                    failed = 1'b1;
                end
            end
            sender_gap();
        end

        // Random streams over small alphabets, so that strings repeat
        left = N_RANDOM;
        while (left > 0)
        begin
            run_len = $urandom_range(1, 40);
            alpha   = 8'($urandom_range(1, 255));
            for (i = 0; i < run_len && left > 0; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    b = 8'($urandom);
                else
                    b = ($urandom_range(0, 1) == 1) ? alpha : ~alpha;
                left--;
                send_byte(b, (i == run_len - 1) || (left == 0));
                sender_gap();
            end
        end
        src_valid <= 1'b0;

        // Wait for the block to drain, then a short tail
        while (expected_bytes.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (!failed && expected_bytes.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Generous limit: clearing pass plus every byte at its slowest
    initial
    begin
        #(20 * 2000000);
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
